>>> rtl/dqpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq current PI controller package
// Widths, command codes, the controller-to-datapath command record and the
// quarter-wave sine table of the datapath.
// ----------------------------------------------------------------------------
package dqpi_pkg;

    // Field widths
    localparam int SAMPLE_WIDTH     = 16;
    localparam int ANGLE_WIDTH      = 16;
    localparam int SUM_WIDTH        = 32;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int GAIN_WIDTH       = 16;
    localparam int VLIM_WIDTH       = SAMPLE_WIDTH - 1;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH   = (GAIN_WIDTH > ANGLE_WIDTH) ? GAIN_WIDTH : ANGLE_WIDTH;

    // Sine table geometry
    localparam int QSHIFT = ANGLE_WIDTH - 2;
    localparam int TAB_AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int TAB_DW = SAMPLE_WIDTH - 1;

    // Datapath widths: wide intermediate values, multiplier operands, accumulator
    localparam int VW     = SAMPLE_WIDTH + 2;
    localparam int OPA_W  = (SUM_WIDTH > VW) ? SUM_WIDTH : VW;
    localparam int OPB_W  = 18;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W + 2;

    // Fixed-point constants of the transforms
    localparam int K_CLARKE_A = 21845;
    localparam int K_CLARKE_B = 37837;
    localparam int K_INV_B    = 56756;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KP_D       = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KP_Q       = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KI_TS_D    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KI_TS_Q    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANGLE_STEP = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPEED_MODE = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VDC_HALF   = 3'd6;

    // Sine/cosine table access
    localparam logic [1:0] TRIG_NONE = 2'd0;
    localparam logic [1:0] TRIG_SIN  = 2'd1;
    localparam logic [1:0] TRIG_COS  = 2'd2;

    // Multiplier operand selection
    localparam logic [3:0] M_NONE = 4'd0;
    localparam logic [3:0] M_CLA  = 4'd1;
    localparam logic [3:0] M_CLB  = 4'd2;
    localparam logic [3:0] M_AC   = 4'd3;
    localparam logic [3:0] M_BS   = 4'd4;
    localparam logic [3:0] M_BC   = 4'd5;
    localparam logic [3:0] M_AS   = 4'd6;
    localparam logic [3:0] M_KPD  = 4'd7;
    localparam logic [3:0] M_KID  = 4'd8;
    localparam logic [3:0] M_KPQ  = 4'd9;
    localparam logic [3:0] M_KIQ  = 4'd10;
    localparam logic [3:0] M_DC   = 4'd11;
    localparam logic [3:0] M_QS   = 4'd12;
    localparam logic [3:0] M_DS   = 4'd13;
    localparam logic [3:0] M_QC   = 4'd14;
    localparam logic [3:0] M_BE   = 4'd15;

    // Accumulator operations
    localparam logic [2:0] A_HOLD  = 3'd0;
    localparam logic [2:0] A_LOAD  = 3'd1;
    localparam logic [2:0] A_ADD   = 3'd2;
    localparam logic [2:0] A_SUB   = 3'd3;
    localparam logic [2:0] A_ALADD = 3'd4;
    localparam logic [2:0] A_ALSUB = 3'd5;

    // Result register selection
    localparam logic [3:0] S_NONE  = 4'd0;
    localparam logic [3:0] S_ALPHA = 4'd1;
    localparam logic [3:0] S_BETA  = 4'd2;
    localparam logic [3:0] S_MD    = 4'd3;
    localparam logic [3:0] S_MQ    = 4'd4;
    localparam logic [3:0] S_VD    = 4'd5;
    localparam logic [3:0] S_VQ    = 4'd6;
    localparam logic [3:0] S_AL    = 4'd7;
    localparam logic [3:0] S_BE    = 4'd8;
    localparam logic [3:0] S_VB    = 4'd9;
    localparam logic [3:0] S_VC    = 4'd10;

    // Error sum update selection
    localparam logic [1:0] SUM_NONE = 2'd0;
    localparam logic [1:0] SUM_D    = 2'd1;
    localparam logic [1:0] SUM_Q    = 2'd2;

    typedef struct packed {
        logic       load;
        logic [1:0] trig_rd;
        logic [1:0] trig_wr;
        logic [3:0] mul_sel;
        logic [2:0] acc_op;
        logic [3:0] st_sel;
        logic [1:0] sum_sel;
        logic       out_load;
    } t_cmd;

    typedef logic [TAB_DW-1:0] t_sin_tab [0:SINE_TABLE_DEPTH];

    // Quarter-wave sine: Horner series in Q30, each entry rounded to Q15
    function automatic t_sin_tab build_sin_tab();
        t_sin_tab                 tab;
        longint unsigned          x;
        longint unsigned          x2;
        longint unsigned          t;
        longint unsigned          s;
        longint unsigned          one_q30;
        longint unsigned          half_pi_q30;
        one_q30     = 64'd1 << 30;
        half_pi_q30 = 64'd1686629713;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x  = (longint'(k) * half_pi_q30) / SINE_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            t  = one_q30;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd110;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd72;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd42;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd20;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd6;
            s      = (x * t) >> 30;
            tab[k] = TAB_DW'((s * 64'd32767 + (64'd1 << 29)) >> 30);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

endpackage
`default_nettype wire

>>> rtl/dq_current_pi_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq current PI controller
// Field oriented current control tick: Clarke and Park transforms, PI law
// per axis with saturating error sums, inverse transforms, voltage clamp.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_ready   currents, references, angle
//  out      from block o_out_valid / i_out_ready phase voltages, d/q, angle
//  cfg      to block   i_cfg_valid / o_cfg_ready register index and data
//
//  One tick walks 23 schedule steps through the single shared 32x18
//  multiplier and its accumulator, between accept and result hand-off. A
//  new request is taken once the previous result sits in the output
//  register, even if it has not been read. Reset is synchronous and
//  active low; the table is constant, so no clearing pass follows reset.
//  Configuration writes are always taken.
// ----------------------------------------------------------------------------
module dq_current_pi_controller (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_in_valid,
    output logic                                               o_in_ready,
    input  wire logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]      i_current_a,
    input  wire logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]      i_current_b,
    input  wire logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]      i_current_c,
    input  wire logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]      i_d_reference,
    input  wire logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]      i_q_reference,
    input  wire logic [dqpi_pkg::ANGLE_WIDTH-1:0]              i_given_angle,
    output logic                                               o_out_valid,
    input  wire logic                                          i_out_ready,
    output logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]           o_volt_a,
    output logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]           o_volt_b,
    output logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]           o_volt_c,
    output logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]           o_measured_d,
    output logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]           o_measured_q,
    output logic [dqpi_pkg::ANGLE_WIDTH-1:0]                   o_angle_used,
    input  wire logic                                          i_cfg_valid,
    output logic                                               o_cfg_ready,
    input  wire logic [dqpi_pkg::CFG_INDEX_WIDTH-1:0]          i_cfg_index,
    input  wire logic [dqpi_pkg::CFG_DATA_WIDTH-1:0]           i_cfg_data
);
    import dqpi_pkg::*;

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    dqpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    dqpi_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_current_a   (i_current_a),
        .i_current_b   (i_current_b),
        .i_current_c   (i_current_c),
        .i_d_reference (i_d_reference),
        .i_q_reference (i_q_reference),
        .i_given_angle (i_given_angle),
        .o_volt_a      (o_volt_a),
        .o_volt_b      (o_volt_b),
        .o_volt_c      (o_volt_c),
        .o_measured_d  (o_measured_d),
        .o_measured_q  (o_measured_q),
        .o_angle_used  (o_angle_used)
    );

endmodule
`default_nettype wire

>>> rtl/dqpi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq current PI controller sequencer
// Walks the fixed schedule of one control tick and issues a command record
// to the datapath each cycle; owns the request handshakes.
// ----------------------------------------------------------------------------
module dqpi_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output dqpi_pkg::t_cmd    o_cmd
);
    import dqpi_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int          STEP_W    = 5;
    localparam logic [4:0]  LAST_STEP = 5'd22;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_out_valid;
    logic              n_out_valid;
    t_cmd              cmd;

    // Take a new request only between ticks
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Decode the schedule step into datapath commands
    always_comb begin
        cmd          = '0;
        cmd.trig_rd  = TRIG_NONE;
        cmd.trig_wr  = TRIG_NONE;
        cmd.mul_sel  = M_NONE;
        cmd.acc_op   = A_HOLD;
        cmd.st_sel   = S_NONE;
        cmd.sum_sel  = SUM_NONE;
        cmd.load     = i_in_valid && (r_state == ST_IDLE);
        cmd.out_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
        if (r_state == ST_RUN) begin
            case (r_step)
                // Table reads and Clarke transform
                5'd0: begin
                    cmd.trig_rd = TRIG_SIN;
                    cmd.mul_sel = M_CLA;
                end
                5'd1: begin
                    cmd.trig_wr = TRIG_SIN;
                    cmd.trig_rd = TRIG_COS;
                    cmd.acc_op  = A_LOAD;
                    cmd.mul_sel = M_CLB;
                end
                5'd2: begin
                    cmd.trig_wr = TRIG_COS;
                    cmd.st_sel  = S_ALPHA;
                    cmd.acc_op  = A_LOAD;
                end
                5'd3: cmd.st_sel = S_BETA;
                // Park transform
                5'd4: cmd.mul_sel = M_AC;
                5'd5: begin
                    cmd.mul_sel = M_BS;
                    cmd.acc_op  = A_LOAD;
                end
                5'd6: begin
                    cmd.mul_sel = M_BC;
                    cmd.acc_op  = A_ADD;
                end
                5'd7: begin
                    cmd.st_sel  = S_MD;
                    cmd.mul_sel = M_AS;
                    cmd.acc_op  = A_LOAD;
                end
                // PI laws
                5'd8: begin
                    cmd.acc_op  = A_SUB;
                    cmd.sum_sel = SUM_D;
                    cmd.mul_sel = M_KPD;
                end
                5'd9: begin
                    cmd.st_sel  = S_MQ;
                    cmd.mul_sel = M_KID;
                    cmd.acc_op  = A_LOAD;
                end
                5'd10: begin
                    cmd.acc_op  = A_ADD;
                    cmd.sum_sel = SUM_Q;
                    cmd.mul_sel = M_KPQ;
                end
                5'd11: begin
                    cmd.st_sel  = S_VD;
                    cmd.mul_sel = M_KIQ;
                    cmd.acc_op  = A_LOAD;
                end
                // Inverse Park transform
                5'd12: begin
                    cmd.acc_op  = A_ADD;
                    cmd.mul_sel = M_DC;
                end
                5'd13: begin
                    cmd.st_sel = S_VQ;
                    cmd.acc_op = A_LOAD;
                end
                5'd14: cmd.mul_sel = M_QS;
                5'd15: begin
                    cmd.acc_op  = A_SUB;
                    cmd.mul_sel = M_DS;
                end
                5'd16: begin
                    cmd.st_sel  = S_AL;
                    cmd.acc_op  = A_LOAD;
                    cmd.mul_sel = M_QC;
                end
                5'd17: cmd.acc_op = A_ADD;
                5'd18: cmd.st_sel = S_BE;
                // Inverse Clarke transform
                5'd19: cmd.mul_sel = M_BE;
                5'd20: cmd.acc_op  = A_ALADD;
                5'd21: begin
                    cmd.st_sel = S_VB;
                    cmd.acc_op = A_ALSUB;
                end
                5'd22: cmd.st_sel = S_VC;
                default: cmd.st_sel = S_NONE;
            endcase
        end
    end

    assign o_cmd = cmd;

    // Advance through idle, schedule and result hand-off
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (cmd.out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an unread result");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_RUN && r_step == '0))
        else $error("accepted request did not start the schedule");

    a_run_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step != LAST_STEP) |=>
            (r_state == ST_RUN && r_step == STEP_W'($past(r_step) + 1'b1)))
        else $error("schedule step skipped");
`endif

endmodule
`default_nettype wire

>>> rtl/dqpi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq current PI controller datapath
// Configuration registers, angle, sine table, one shared multiplier with an
// accumulator, intermediate registers, error sums and the result register.
// ----------------------------------------------------------------------------
module dqpi_datapath (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire dqpi_pkg::t_cmd                                i_cmd,
    input  wire logic                                          i_cfg_valid,
    input  wire logic [dqpi_pkg::CFG_INDEX_WIDTH-1:0]          i_cfg_index,
    input  wire logic [dqpi_pkg::CFG_DATA_WIDTH-1:0]           i_cfg_data,
    input  wire logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]      i_current_a,
    input  wire logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]      i_current_b,
    input  wire logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]      i_current_c,
    input  wire logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]      i_d_reference,
    input  wire logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]      i_q_reference,
    input  wire logic [dqpi_pkg::ANGLE_WIDTH-1:0]              i_given_angle,
    output logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]           o_volt_a,
    output logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]           o_volt_b,
    output logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]           o_volt_c,
    output logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]           o_measured_d,
    output logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]           o_measured_q,
    output logic [dqpi_pkg::ANGLE_WIDTH-1:0]                   o_angle_used
);
    import dqpi_pkg::*;

    localparam logic signed [ACC_W-1:0] SMAX_W = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SMIN_W = -(ACC_W'(64'sd1 <<< (SAMPLE_WIDTH - 1)));
    localparam logic [ANGLE_WIDTH-1:0]  QUARTER = ANGLE_WIDTH'(1) << QSHIFT;
    localparam int                      SC_W    = QSHIFT + TAB_AW;

    // Configuration
    logic [GAIN_WIDTH-1:0]         r_kp_d;
    logic [GAIN_WIDTH-1:0]         r_kp_q;
    logic [GAIN_WIDTH-1:0]         r_ki_d;
    logic [GAIN_WIDTH-1:0]         r_ki_q;
    logic [ANGLE_WIDTH-1:0]        r_angle_step;
    logic                          r_speed_mode;
    logic [VLIM_WIDTH-1:0]         r_vdc_half;

    // Tick state and working registers
    logic [ANGLE_WIDTH-1:0]        r_angle;
    logic signed [SUM_WIDTH-1:0]   r_sum_d;
    logic signed [SUM_WIDTH-1:0]   r_sum_q;
    logic signed [VW-1:0]          r_cla;
    logic signed [VW-1:0]          r_clb;
    logic signed [SAMPLE_WIDTH-1:0] r_dref;
    logic signed [SAMPLE_WIDTH-1:0] r_qref;
    logic [TAB_DW-1:0]             r_rom;
    logic signed [SAMPLE_WIDTH-1:0] r_sin;
    logic signed [SAMPLE_WIDTH-1:0] r_cos;
    logic signed [VW-1:0]          r_alpha;
    logic signed [VW-1:0]          r_beta;
    logic signed [SAMPLE_WIDTH-1:0] r_md;
    logic signed [SAMPLE_WIDTH-1:0] r_mq;
    logic signed [SAMPLE_WIDTH-1:0] r_vd;
    logic signed [SAMPLE_WIDTH-1:0] r_vq;
    logic signed [VW-1:0]          r_al;
    logic signed [VW-1:0]          r_be;
    logic signed [VW-1:0]          r_vb;
    logic signed [VW-1:0]          r_vc;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       n_acc;

    logic [ANGLE_WIDTH-1:0]        cos_angle;
    logic [TAB_AW-1:0]             rd_addr;
    logic [1:0]                    wr_quad;
    logic signed [SAMPLE_WIDTH:0]  err_d;
    logic signed [SAMPLE_WIDTH:0]  err_q;
    logic signed [OPA_W-1:0]       op_a;
    logic signed [OPB_W-1:0]       op_b;
    logic signed [ACC_W-1:0]       al_sh;
    logic signed [ACC_W-1:0]       rnd8;
    logic signed [ACC_W-1:0]       rnd15;
    logic signed [ACC_W-1:0]       rnd16;

    // Table address of an angle: quadrant mirrors, index scaled to the depth
    function automatic logic [TAB_AW-1:0] trig_addr(input logic [ANGLE_WIDTH-1:0] ang);
        logic [SC_W-1:0]   sc;
        logic [TAB_AW-1:0] idx;
        sc  = SC_W'(ang[QSHIFT-1:0]) * SC_W'(SINE_TABLE_DEPTH);
        idx = sc[QSHIFT +: TAB_AW];
        return ang[ANGLE_WIDTH-2] ? (TAB_AW'(SINE_TABLE_DEPTH) - idx) : idx;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v);
        if (v > SMAX_W) begin
            return SAMPLE_WIDTH'(SMAX_W);
        end else if (v < SMIN_W) begin
            return SAMPLE_WIDTH'(SMIN_W);
        end
        return SAMPLE_WIDTH'(v);
    endfunction

    function automatic logic signed [SUM_WIDTH-1:0] sum_update(
        input logic signed [SUM_WIDTH-1:0] s, input logic signed [SAMPLE_WIDTH:0] e);
        logic signed [SUM_WIDTH:0] t;
        t = (SUM_WIDTH+1)'(s) + (SUM_WIDTH+1)'(e);
        if (t[SUM_WIDTH] != t[SUM_WIDTH-1]) begin
            return t[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
        return t[SUM_WIDTH-1:0];
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] clamp_volt(
        input logic signed [VW-1:0] v, input logic [VLIM_WIDTH-1:0] lim);
        logic signed [VW-1:0] lim_s;
        lim_s = $signed(VW'(lim));
        if (v > lim_s) begin
            return SAMPLE_WIDTH'(lim_s);
        end else if (v < -lim_s) begin
            return SAMPLE_WIDTH'(-lim_s);
        end
        return SAMPLE_WIDTH'(v);
    endfunction

    // Table addressing for sine and cosine
    assign cos_angle = r_angle + QUARTER;
    assign rd_addr   = (i_cmd.trig_rd == TRIG_COS) ? trig_addr(cos_angle) : trig_addr(r_angle);
    assign wr_quad   = (i_cmd.trig_wr == TRIG_COS) ? cos_angle[ANGLE_WIDTH-1 -: 2]
                                                   : r_angle[ANGLE_WIDTH-1 -: 2];

    // Axis errors
    assign err_d = (SAMPLE_WIDTH+1)'(r_dref) - (SAMPLE_WIDTH+1)'(r_md);
    assign err_q = (SAMPLE_WIDTH+1)'(r_qref) - (SAMPLE_WIDTH+1)'(r_mq);

    // Select multiplier operands
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.mul_sel)
            M_CLA: begin op_a = OPA_W'(r_cla);   op_b = OPB_W'(K_CLARKE_A);       end
            M_CLB: begin op_a = OPA_W'(r_clb);   op_b = OPB_W'(K_CLARKE_B);       end
            M_AC:  begin op_a = OPA_W'(r_alpha); op_b = OPB_W'(r_cos);            end
            M_BS:  begin op_a = OPA_W'(r_beta);  op_b = OPB_W'(r_sin);            end
            M_BC:  begin op_a = OPA_W'(r_beta);  op_b = OPB_W'(r_cos);            end
            M_AS:  begin op_a = OPA_W'(r_alpha); op_b = OPB_W'(r_sin);            end
            M_KPD: begin op_a = OPA_W'(err_d);   op_b = OPB_W'({1'b0, r_kp_d});   end
            M_KID: begin op_a = OPA_W'(r_sum_d); op_b = OPB_W'({1'b0, r_ki_d});   end
            M_KPQ: begin op_a = OPA_W'(err_q);   op_b = OPB_W'({1'b0, r_kp_q});   end
            M_KIQ: begin op_a = OPA_W'(r_sum_q); op_b = OPB_W'({1'b0, r_ki_q});   end
            M_DC:  begin op_a = OPA_W'(r_vd);    op_b = OPB_W'(r_cos);            end
            M_QS:  begin op_a = OPA_W'(r_vq);    op_b = OPB_W'(r_sin);            end
            M_DS:  begin op_a = OPA_W'(r_vd);    op_b = OPB_W'(r_sin);            end
            M_QC:  begin op_a = OPA_W'(r_vq);    op_b = OPB_W'(r_cos);            end
            M_BE:  begin op_a = OPA_W'(r_be);    op_b = OPB_W'(K_INV_B);          end
            default: begin op_a = '0;            op_b = '0;                       end
        endcase
    end

    // Accumulate the registered product; alpha term of inverse Clarke is a shift
    assign al_sh = ACC_W'(r_al) <<< 15;

    always_comb begin
        case (i_cmd.acc_op)
            A_LOAD:  n_acc = ACC_W'(r_prod);
            A_ADD:   n_acc = r_acc + ACC_W'(r_prod);
            A_SUB:   n_acc = r_acc - ACC_W'(r_prod);
            A_ALADD: n_acc = ACC_W'(r_prod) - al_sh;
            A_ALSUB: n_acc = -al_sh - ACC_W'(r_prod);
            default: n_acc = r_acc;
        endcase
    end

    // Round to nearest, ties up, at each of the three scalings
    assign rnd8  = (r_acc + ACC_W'(128)) >>> 8;
    assign rnd15 = (r_acc + ACC_W'(16384)) >>> 15;
    assign rnd16 = (r_acc + ACC_W'(32768)) >>> 16;

    // Configuration, angle and error sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_d       <= '0;
            r_kp_q       <= '0;
            r_ki_d       <= '0;
            r_ki_q       <= '0;
            r_angle_step <= '0;
            r_speed_mode <= 1'b1;
            r_vdc_half   <= '1;
            r_angle      <= '0;
            r_sum_d      <= '0;
            r_sum_q      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KP_D:    r_kp_d <= i_cfg_data[GAIN_WIDTH-1:0];
                    CFG_KP_Q:    r_kp_q <= i_cfg_data[GAIN_WIDTH-1:0];
                    CFG_KI_TS_D: r_ki_d <= i_cfg_data[GAIN_WIDTH-1:0];
                    CFG_KI_TS_Q: r_ki_q <= i_cfg_data[GAIN_WIDTH-1:0];
                    CFG_ANGLE_STEP: begin
                        // Ignore in angle mode; a zero step also parks the angle
                        if (r_speed_mode) begin
                            r_angle_step <= i_cfg_data[ANGLE_WIDTH-1:0];
                            if (i_cfg_data[ANGLE_WIDTH-1:0] == '0) begin
                                r_angle <= '0;
                            end
                        end
                    end
                    CFG_SPEED_MODE: r_speed_mode <= i_cfg_data[0];
                    CFG_VDC_HALF:   r_vdc_half   <= i_cfg_data[VLIM_WIDTH-1:0];
                    default:        r_speed_mode <= r_speed_mode;
                endcase
            end
            if (i_cmd.load) begin
                r_angle <= r_speed_mode ? (r_angle + r_angle_step) : i_given_angle;
            end
            if (i_cmd.sum_sel == SUM_D) begin
                r_sum_d <= sum_update(r_sum_d, err_d);
            end
            if (i_cmd.sum_sel == SUM_Q) begin
                r_sum_q <= sum_update(r_sum_q, err_q);
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cla  <= (VW'(i_current_a) <<< 1) - VW'(i_current_b) - VW'(i_current_c);
            r_clb  <= VW'(i_current_b) - VW'(i_current_c);
            r_dref <= i_d_reference;
            r_qref <= i_q_reference;
        end
        r_rom <= SIN_TAB[rd_addr];
        if (i_cmd.trig_wr == TRIG_SIN) begin
            r_sin <= wr_quad[1] ? -$signed({1'b0, r_rom}) : $signed({1'b0, r_rom});
        end
        if (i_cmd.trig_wr == TRIG_COS) begin
            r_cos <= wr_quad[1] ? -$signed({1'b0, r_rom}) : $signed({1'b0, r_rom});
        end
        if (i_cmd.mul_sel != M_NONE) begin
            r_prod <= op_a * op_b;
        end
        r_acc <= n_acc;
        case (i_cmd.st_sel)
            S_ALPHA: r_alpha <= VW'(rnd16);
            S_BETA:  r_beta  <= VW'(rnd16);
            S_MD:    r_md    <= sat_sample(rnd15);
            S_MQ:    r_mq    <= sat_sample(rnd15);
            S_VD:    r_vd    <= sat_sample(rnd8);
            S_VQ:    r_vq    <= sat_sample(rnd8);
            S_AL:    r_al    <= VW'(rnd15);
            S_BE:    r_be    <= VW'(rnd15);
            S_VB:    r_vb    <= VW'(rnd16);
            S_VC:    r_vc    <= VW'(rnd16);
            default: ;
        endcase
        // Result register
        if (i_cmd.out_load) begin
            o_volt_a     <= clamp_volt(r_al, r_vdc_half);
            o_volt_b     <= clamp_volt(r_vb, r_vdc_half);
            o_volt_c     <= clamp_volt(r_vc, r_vdc_half);
            o_measured_d <= r_md;
            o_measured_q <= r_mq;
            o_angle_used <= r_angle;
        end
    end

`ifndef NO_ASSERTIONS
    a_angle_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && r_speed_mode && !i_cfg_valid) |=>
            (r_angle == ANGLE_WIDTH'($past(r_angle) + $past(r_angle_step))))
        else $error("angle did not advance by the step");
`endif

endmodule
`default_nettype wire
